// ===== src/regex_pattern_lexer_assert.svh =====
// ----------------------------------------------------------------------------
// Regex pattern lexer assertion macros
// Concurrent assertion wrappers, clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef REGEX_PATTERN_LEXER_ASSERT_SVH
`define REGEX_PATTERN_LEXER_ASSERT_SVH

`ifndef SYNTHESIS
`define RPL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define RPL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RPL_ASSERT(lbl, prop, msg)
`define RPL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/rpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Regex pattern lexer package
// Token kinds, character codes, token and control structs, helper functions.
// ----------------------------------------------------------------------------
package rpl_pkg;

	localparam int MAX_PATTERN = 4096;
	localparam int CNT_W       = $clog2(MAX_PATTERN);
	localparam int OFFSET_W    = 12;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int FIFO_LW     = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_PIPE   = 8'h7c;
	localparam logic [7:0] CH_QUEST  = 8'h3f;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_CARET  = 8'h5e;
	localparam logic [7:0] CH_DOLLAR = 8'h24;

	typedef enum logic [3:0] {
		KIND_LIT   = 4'd0,
		KIND_OPEN  = 4'd1,
		KIND_CLOSE = 4'd2,
		KIND_STAR  = 4'd3,
		KIND_PLUS  = 4'd4,
		KIND_PIPE  = 4'd5,
		KIND_QUEST = 4'd6,
		KIND_LBR   = 4'd7,
		KIND_RBR   = 4'd8,
		KIND_DOT   = 4'd9,
		KIND_BSL   = 4'd10,
		KIND_SA    = 4'd11,
		KIND_EA    = 4'd12,
		KIND_NEG   = 4'd13
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t             kind;
		logic [7:0]            glyph;
		logic [OFFSET_W-1:0]   offset;
		logic                  in_class;
		logic [7:0]            escaped_glyph;
		logic                  escape_is_sequence;
		logic [OFFSET_W-1:0]   ordinal;
		logic                  final_token;
	} token_t;

	typedef struct packed {
		logic one;
		logic two;
	} push_t;

	typedef struct packed {
		logic               room;
		logic [FIFO_LW-1:0] level;
	} fifo_status_t;

	typedef struct packed {
		logic held_valid;
		logic class_open;
	} lex_status_t;

	function automatic tok_kind_t classify(input logic [7:0] c);
		tok_kind_t k;
		unique case (c)
			CH_LPAREN: k = KIND_OPEN;
			CH_RPAREN: k = KIND_CLOSE;
			CH_STAR:   k = KIND_STAR;
			CH_PLUS:   k = KIND_PLUS;
			CH_PIPE:   k = KIND_PIPE;
			CH_QUEST:  k = KIND_QUEST;
			CH_LBRACK: k = KIND_LBR;
			CH_RBRACK: k = KIND_RBR;
			CH_DOT:    k = KIND_DOT;
			CH_BSLASH: k = KIND_BSL;
			default:   k = KIND_LIT;
		endcase
		return k;
	endfunction

	function automatic logic is_sequence(input logic [7:0] c);
		return (c == 8'h64) || (c == 8'h77) || (c == 8'h73) ||
			(c == 8'h6e) || (c == 8'h74) || (c == 8'h62);
	endfunction

	function automatic logic [CNT_W-1:0] wrap_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_W'(MAX_PATTERN - 1)) ? '0 : v + CNT_W'(1);
	endfunction

endpackage

// ===== src/regex_pattern_lexer.sv =====
// ----------------------------------------------------------------------------
// Regex pattern lexer
// Turns a stream of regex pattern bytes into a stream of tokens.
// ----------------------------------------------------------------------------
// Input channel: pattern_valid / pattern_stall carry pattern_byte and
// is_final; is_final marks the last byte of a pattern. Output channel:
// token_valid / token_stall carry one token per transfer.
// A byte transfer lands in the input register; from there, once the token
// queue has room, the lexer classifies it and writes its tokens into a
// four-entry token queue, whose registers offer them in turn. Each token
// waits for the following byte as lookahead, so it is queued with the byte
// that decides it; the final byte flushes every pending token (up to two).
// Throughput: one byte per cycle while the token queue has room. A byte that
// ends a pattern after a held token yields two tokens; the output drains one
// token per cycle while the receiver does not stall. When it stalls, the head
// token holds; once the queue holds more than two tokens, the input register
// holds and pattern_stall rises. Reset clears lexer state and the queue; the
// first byte after reset or after a final byte starts a new pattern.
// ----------------------------------------------------------------------------
`include "regex_pattern_lexer_assert.svh"

module regex_pattern_lexer import rpl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pattern_valid,
	output logic                pattern_stall,
	input  logic [7:0]          pattern_byte,
	input  logic                is_final,
	output logic                token_valid,
	input  logic                token_stall,
	output logic [3:0]          kind,
	output logic [7:0]          glyph,
	output logic [OFFSET_W-1:0] offset,
	output logic                in_class,
	output logic [7:0]          escaped_glyph,
	output logic                escape_is_sequence,
	output logic [OFFSET_W-1:0] ordinal,
	output logic                final_token
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         fin_s1;
	logic         adv;
	logic         take;
	push_t        push;
	token_t       tok0;
	token_t       tok1;
	token_t       head;
	fifo_status_t fifo_st;
	lex_status_t  lex_st;

	assign adv           = valid_s1 && fifo_st.room;
	assign pattern_stall = valid_s1 && !fifo_st.room;
	assign take          = pattern_valid && !pattern_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= pattern_byte;
			fin_s1  <= is_final;
		end
	end

	rpl_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_s1 (byte_s1),
		.fin_s1  (fin_s1),
		.push    (push),
		.tok0    (tok0),
		.tok1    (tok1),
		.status  (lex_st)
	);

	rpl_token_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.tok0        (tok0),
		.tok1        (tok1),
		.token_stall (token_stall),
		.token_valid (token_valid),
		.head        (head),
		.status      (fifo_st)
	);

	assign kind               = head.kind;
	assign glyph              = head.glyph;
	assign offset             = head.offset;
	assign in_class           = head.in_class;
	assign escaped_glyph      = head.escaped_glyph;
	assign escape_is_sequence = head.escape_is_sequence;
	assign ordinal            = head.ordinal;
	assign final_token        = head.final_token;

	`RPL_ASSERT(a_queue_bound, fifo_st.level <= FIFO_LW'(FIFO_DEPTH), "token queue overflow")
	`RPL_ASSERT(a_push_order, !push.two || push.one, "second token pushed without first")
	`RPL_ASSERT_NEXT(a_final_clears, adv && fin_s1, !lex_st.held_valid && !lex_st.class_open, "lexer state not cleared after final byte")

endmodule

// ===== src/rpl_lexer.sv =====
// ----------------------------------------------------------------------------
// Regex pattern lexer core
// Classifies one pattern byte per advance, holds one token for lookahead and
// produces up to two tokens.
// ----------------------------------------------------------------------------
module rpl_lexer import rpl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic [7:0]  byte_s1,
	input  logic        fin_s1,
	output push_t       push,
	output token_t      tok0,
	output token_t      tok1,
	output lex_status_t status
);

	logic             class_open_q, class_open_d;
	logic [7:0]       prior_q, prior_d;
	logic [CNT_W-1:0] pos_q, pos_d;
	logic             held_valid_q, held_valid_d;
	logic [7:0]       held_byte_q, held_byte_d;
	logic [CNT_W-1:0] held_pos_q, held_pos_d;
	tok_kind_t        held_kind_q, held_kind_d;
	logic             held_cls_q, held_cls_d;
	logic [CNT_W-1:0] emitted_q, emitted_d;

	logic [CNT_W-1:0] emitted_p1;
	logic [CNT_W-1:0] pos_p1;
	tok_kind_t        hk;
	tok_kind_t        k;
	logic             cls;
	logic             incls;
	token_t           held_tok;
	token_t           cur_tok;

	always_comb begin
		emitted_p1 = wrap_inc(emitted_q);
		pos_p1     = wrap_inc(pos_q);

		hk = held_kind_q;
		if (held_byte_q == CH_DOLLAR && (byte_s1 == CH_RPAREN || byte_s1 == CH_PIPE ||
			byte_s1 == CH_RBRACK)) begin
			hk = KIND_EA;
		end

		k   = classify(byte_s1);
		cls = class_open_q;
		if (k == KIND_LBR) begin
			cls = 1'b1;
		end
		if (k == KIND_RBR) begin
			cls = 1'b0;
		end
		if (byte_s1 == CH_CARET && (prior_q == CH_NUL || prior_q == CH_LPAREN ||
			prior_q == CH_PIPE)) begin
			k = KIND_SA;
		end
		if (cls) begin
			if (k == KIND_STAR || k == KIND_QUEST || k == KIND_PLUS) begin
				k = KIND_LIT;
			end
			if (byte_s1 == CH_CARET) begin
				k = KIND_NEG;
			end
		end
		incls = cls && k != KIND_LBR && k != KIND_RBR;
		if (fin_s1 && byte_s1 == CH_DOLLAR) begin
			k = KIND_EA;
		end

		held_tok.kind               = hk;
		held_tok.glyph              = held_byte_q;
		held_tok.offset             = OFFSET_W'(held_pos_q);
		held_tok.in_class           = held_cls_q;
		held_tok.escaped_glyph      = '0;
		held_tok.escape_is_sequence = 1'b0;
		held_tok.ordinal            = OFFSET_W'(emitted_q);
		held_tok.final_token        = 1'b0;

		cur_tok.kind               = k;
		cur_tok.glyph              = byte_s1;
		cur_tok.offset             = OFFSET_W'(pos_q);
		cur_tok.in_class           = incls;
		cur_tok.escaped_glyph      = '0;
		cur_tok.escape_is_sequence = 1'b0;
		cur_tok.ordinal            = OFFSET_W'(held_valid_q ? emitted_p1 : emitted_q);
		cur_tok.final_token        = 1'b1;

		push = '0;
		tok0 = held_tok;
		tok1 = cur_tok;

		class_open_d = class_open_q;
		prior_d      = prior_q;
		pos_d        = pos_q;
		held_valid_d = held_valid_q;
		held_byte_d  = held_byte_q;
		held_pos_d   = held_pos_q;
		held_kind_d  = held_kind_q;
		held_cls_d   = held_cls_q;
		emitted_d    = emitted_q;

		if (adv) begin
			if (held_valid_q && held_kind_q == KIND_BSL) begin
				tok0.kind               = KIND_BSL;
				tok0.escaped_glyph      = byte_s1;
				tok0.escape_is_sequence = is_sequence(byte_s1);
				tok0.final_token        = fin_s1;
				push.one                = 1'b1;
				held_valid_d            = 1'b0;
				prior_d                 = byte_s1;
				pos_d                   = pos_p1;
				emitted_d               = emitted_p1;
			end else begin
				push.one = held_valid_q;
				if (fin_s1) begin
					if (held_valid_q) begin
						push.two = 1'b1;
					end else begin
						tok0     = cur_tok;
						push.one = 1'b1;
					end
				end else begin
					held_valid_d = 1'b1;
					held_byte_d  = byte_s1;
					held_pos_d   = pos_q;
					held_kind_d  = k;
					held_cls_d   = incls;
					prior_d      = byte_s1;
					pos_d        = pos_p1;
					class_open_d = cls;
					emitted_d    = held_valid_q ? emitted_p1 : emitted_q;
				end
			end
			if (fin_s1) begin
				class_open_d = 1'b0;
				prior_d      = '0;
				pos_d        = '0;
				held_valid_d = 1'b0;
				held_byte_d  = '0;
				held_pos_d   = '0;
				held_kind_d  = KIND_LIT;
				held_cls_d   = 1'b0;
				emitted_d    = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_open_q <= 1'b0;
			prior_q      <= '0;
			pos_q        <= '0;
			held_valid_q <= 1'b0;
			held_byte_q  <= '0;
			held_pos_q   <= '0;
			held_kind_q  <= KIND_LIT;
			held_cls_q   <= 1'b0;
			emitted_q    <= '0;
		end else begin
			class_open_q <= class_open_d;
			prior_q      <= prior_d;
			pos_q        <= pos_d;
			held_valid_q <= held_valid_d;
			held_byte_q  <= held_byte_d;
			held_pos_q   <= held_pos_d;
			held_kind_q  <= held_kind_d;
			held_cls_q   <= held_cls_d;
			emitted_q    <= emitted_d;
		end
	end

	assign status.held_valid = held_valid_q;
	assign status.class_open = class_open_q;

endmodule

// ===== src/rpl_token_fifo.sv =====
// ----------------------------------------------------------------------------
// Regex pattern lexer token queue
// Register queue: up to two tokens in, one out unless stalled, per cycle.
// ----------------------------------------------------------------------------
module rpl_token_fifo import rpl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  push_t        push,
	input  token_t       tok0,
	input  token_t       tok1,
	input  logic         token_stall,
	output logic         token_valid,
	output token_t       head,
	output fifo_status_t status
);

	token_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [FIFO_LW-1:0]   level_q;
	logic                 pop;
	logic [FIFO_LW-1:0]   n_push;

	assign token_valid  = level_q != '0;
	assign head         = mem_q[rd_q];
	assign pop          = token_valid && !token_stall;
	assign n_push       = FIFO_LW'(push.one) + FIFO_LW'(push.two);
	assign status.room  = level_q <= FIFO_LW'(FIFO_DEPTH - 2);
	assign status.level = level_q;

	always_ff @(posedge clk) begin
		if (push.one) begin
			mem_q[wr_q] <= tok0;
		end
		if (push.two) begin
			mem_q[wr_q + FIFO_AW'(1)] <= tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_AW'(n_push);
			rd_q    <= rd_q + FIFO_AW'(pop);
			level_q <= level_q + n_push - FIFO_LW'(pop);
		end
	end

endmodule
